>>> rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Types and constants shared by the pulse-shape channel calibrator: the
// input and result words, operation codes and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

  // Operation codes carried in the op field of an input word.
  localparam logic OP_CALIBRATE = 1'b0;
  localparam logic OP_WRITE     = 1'b1;

  // Fixed-point constants: one in Q2.30 and one in Q8.24.
  localparam logic signed [32:0] ONE_Q30 = 33'sh0_4000_0000;
  localparam logic signed [35:0] ONE_Q24 = 36'sh0_0100_0000;

  // Input word: a hit to calibrate or a coefficient table entry to load.
  typedef struct packed {
    logic               op;
    logic [15:0]        channel;
    logic signed [31:0] fast_in;
    logic signed [31:0] slow_in;
    logic signed [31:0] coef_scale;
    logic signed [31:0] coef_offset;
  } psc_in_t;

  // Result word: one calibrated hit.
  typedef struct packed {
    logic [15:0]        channel_out;
    logic signed [31:0] fast_out;
    logic signed [31:0] slow_out;
    logic               bad_channel;
  } psc_out_t;

endpackage

`default_nettype wire

>>> rtl/pulse_shape_channel_calibrator.sv
// ----------------------------------------------------------------------------
// pulse_shape_channel_calibrator
// Per-channel fast/slow pulse-shape rebalancing in a six-stage pipeline.
//
// Usage:
//   Words enter on the in_ channel (in_valid, in_stall, in_data) and results
//   leave on the out_ channel (out_valid, out_stall, out_data). A word with
//   op set to write loads the scale and offset of one channel into the
//   coefficient table and gives no result; a write to a channel beyond the
//   table is dropped. A calibrate word gives exactly one result. A channel
//   beyond the table passes its fast and slow values through unchanged with
//   bad_channel set. Entries must be written before they are calibrated.
//   Throughput is one word per cycle while out_stall is low. A result is
//   offered once its word has passed six register stages: table read at
//   acceptance, sum and clamp, two coefficient products, mixing factor and
//   shift, rebalance product, final add and saturation into the output.
//   No stage chains more than one multiplier of about 33 by 32 bits.
//   Reset empties the pipeline but leaves the table contents as they were.
//   When the receiver stalls, the output word holds and the stages behind it
//   close up their empty slots; in_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_shape_channel_calibrator #(
  parameter int NUM_CHANNELS = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire psc_pkg::psc_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output psc_pkg::psc_out_t     out_data
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [16:0] NUM_CH = 17'(NUM_CHANNELS);

  // Saturate a wide signed value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Stage enables: a stage loads when it is empty or the next one loads.
  logic en1, en2, en3, en4, en5, en6;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  psc_pkg::psc_out_t out_data_r;

  assign en6 = !out_valid_r || !out_stall;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_stall  = !en1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic accept;
  logic in_range;
  logic [AW-1:0] addr;

  assign accept   = in_valid && en1;
  assign in_range = 17'(in_data.channel) < NUM_CH;
  assign addr     = in_data.channel[AW-1:0];

  // Coefficient table: scale in the upper half, offset in the lower half.
  logic [63:0] coef_mem [NUM_CHANNELS];
  logic [63:0] coef_rd_r;

  always_ff @(posedge clk) begin
    if (accept && in_data.op == psc_pkg::OP_WRITE && in_range) begin
      coef_mem[addr] <= {in_data.coef_scale, in_data.coef_offset};
    end
    if (en1) begin
      coef_rd_r <= coef_mem[addr];
    end
  end

  // Valid bits travel with the words; write words leave no valid behind.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid && in_data.op == psc_pkg::OP_CALIBRATE;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) out_valid_r <= v5_r;
    end
  end

  // Stage 1: capture the hit next to the table read.
  logic [15:0]        ch1_r;
  logic               bad1_r;
  logic signed [31:0] fast1_r, slow1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      ch1_r   <= in_data.channel;
      bad1_r  <= !in_range;
      fast1_r <= in_data.fast_in;
      slow1_r <= in_data.slow_in;
    end
  end

  // Stage 2: sum, difference, ten times the sum clamped, scale minus one.
  logic signed [32:0] sum_nxt, diff_nxt, scm1_nxt;
  logic signed [36:0] sum10;
  logic signed [31:0] scale1, offset1;

  assign scale1   = coef_rd_r[63:32];
  assign offset1  = coef_rd_r[31:0];
  assign sum_nxt  = 33'(fast1_r) + 33'(slow1_r);
  assign diff_nxt = 33'(fast1_r) - 33'(slow1_r);
  assign sum10    = (37'(sum_nxt) <<< 3) + (37'(sum_nxt) <<< 1);
  assign scm1_nxt = 33'(scale1) - psc_pkg::ONE_Q30;

  logic [15:0]        ch2_r;
  logic               bad2_r;
  logic signed [31:0] fast2_r, slow2_r, t2_r, off2_r;
  logic signed [32:0] sum2_r, diff2_r, scm1_2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      ch2_r    <= ch1_r;
      bad2_r   <= bad1_r;
      fast2_r  <= fast1_r;
      slow2_r  <= slow1_r;
      sum2_r   <= sum_nxt;
      diff2_r  <= diff_nxt;
      t2_r     <= sat32(48'(sum10));
      scm1_2_r <= scm1_nxt;
      off2_r   <= offset1;
    end
  end

  // Stage 3: the two coefficient products with the clamped sum.
  logic signed [64:0] sm1_nxt;
  logic signed [63:0] dp_nxt;

  assign sm1_nxt = 65'(scm1_2_r) * 65'(t2_r);
  assign dp_nxt  = 64'(off2_r) * 64'(t2_r);

  logic [15:0]        ch3_r;
  logic               bad3_r;
  logic signed [31:0] fast3_r, slow3_r;
  logic signed [32:0] sum3_r, diff3_r;
  logic signed [64:0] sm1_3_r;
  logic signed [63:0] dp3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      ch3_r   <= ch2_r;
      bad3_r  <= bad2_r;
      fast3_r <= fast2_r;
      slow3_r <= slow2_r;
      sum3_r  <= sum2_r;
      diff3_r <= diff2_r;
      sm1_3_r <= sm1_nxt;
      dp3_r   <= dp_nxt;
    end
  end

  // Stage 4: mixing factor s, clamped symmetrically, and shift d.
  logic signed [35:0] s_raw;
  logic signed [31:0] s_nxt;
  logic signed [33:0] d_nxt;

  assign s_raw = 36'($signed(sm1_3_r[64:30])) + psc_pkg::ONE_Q24;
  assign d_nxt = dp3_r[63:30];

  always_comb begin
    if (s_raw > 36'sh0_7FFF_FFFF) begin
      s_nxt = 32'sh7FFF_FFFF;
    end else if (s_raw < -36'sh0_7FFF_FFFF) begin
      s_nxt = -32'sh7FFF_FFFF;
    end else begin
      s_nxt = s_raw[31:0];
    end
  end

  logic [15:0]        ch4_r;
  logic               bad4_r;
  logic signed [31:0] fast4_r, slow4_r, s4_r;
  logic signed [32:0] sum4_r, diff4_r;
  logic signed [33:0] d4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      ch4_r   <= ch3_r;
      bad4_r  <= bad3_r;
      fast4_r <= fast3_r;
      slow4_r <= slow3_r;
      sum4_r  <= sum3_r;
      diff4_r <= diff3_r;
      s4_r    <= s_nxt;
      d4_r    <= d_nxt;
    end
  end

  // Stage 5: the rebalance product s times the difference.
  logic signed [64:0] sdp_nxt;

  assign sdp_nxt = 65'(s4_r) * 65'(diff4_r);

  logic [15:0]        ch5_r;
  logic               bad5_r;
  logic signed [31:0] fast5_r, slow5_r;
  logic signed [32:0] sum5_r;
  logic signed [33:0] d5_r;
  logic signed [64:0] sdp5_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      ch5_r   <= ch4_r;
      bad5_r  <= bad4_r;
      fast5_r <= fast4_r;
      slow5_r <= slow4_r;
      sum5_r  <= sum4_r;
      d5_r    <= d4_r;
      sdp5_r  <= sdp_nxt;
    end
  end

  // Stage 6: final sums, halving, saturation and the out-of-table bypass.
  logic signed [40:0] sd;
  logic signed [42:0] acc_f, acc_s;
  psc_pkg::psc_out_t  out_nxt;

  assign sd    = sdp5_r[64:24];
  assign acc_f = 43'(sum5_r) + 43'(sd) - (43'(d5_r) <<< 1);
  assign acc_s = 43'(sum5_r) - 43'(sd) + (43'(d5_r) <<< 1);

  always_comb begin
    out_nxt.channel_out = ch5_r;
    out_nxt.bad_channel = bad5_r;
    if (bad5_r) begin
      out_nxt.fast_out = fast5_r;
      out_nxt.slow_out = slow5_r;
    end else begin
      out_nxt.fast_out = sat32(48'($signed(acc_f[42:1])));
      out_nxt.slow_out = sat32(48'($signed(acc_s[42:1])));
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out_data_r <= out_nxt;
    end
  end

  // A write word never occupies a pipeline slot.
  a_write_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.op == psc_pkg::OP_WRITE |=> !v1_r)
    else $error("write word entered the pipeline");

  // A calibrate word always occupies the first slot.
  a_cal_slot: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.op == psc_pkg::OP_CALIBRATE |=> v1_r)
    else $error("calibrate word was lost at entry");

  // A held word in a blocked stage is not dropped.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !en3 |=> v3_r)
    else $error("blocked stage lost its word");

  // The input side stalls only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && v4_r && v5_r && out_valid_r)
    else $error("input stalled with an empty stage");

  // The bad-channel flag on a result matches its channel number.
  a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.bad_channel == (17'(out_data_r.channel_out) >= NUM_CH))
    else $error("bad_channel flag does not match channel");

endmodule

`default_nettype wire
